/* hdl/mandelbrot_escape_time_macros.svh */
// Assertion macros shared by the checker of the escape-time block.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define MBE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define MBE_ASSERT_IN_RESET(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/mbe_pkg.sv */
// Types, constants and codes shared by the escape-time block.
`default_nettype none

package mbe_pkg;

	localparam int COORD_WIDTH = 12;
	localparam int COUNT_WIDTH = 16;
	localparam int FRAC_BITS = 28;
	localparam int FIX_WIDTH = 32;
	localparam int SIZE_WIDTH = 13;
	localparam int ITER_WIDTH = 16;
	localparam int PROD_WIDTH = 2 * FIX_WIDTH;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH = 32;

	// Magnitude of span times pixel: at most 2^31 * (2^COORD_WIDTH - 1).
	localparam int DIV_WIDTH = FIX_WIDTH + COORD_WIDTH - 1;
	localparam int DIV_CNT_WIDTH = $clog2(DIV_WIDTH);

	localparam logic [PROD_WIDTH-1:0] ESC_LIMIT = 64'd4 << FRAC_BITS;
	localparam logic signed [FIX_WIDTH-1:0] FIX_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [FIX_WIDTH-1:0] FIX_MIN = 32'sh8000_0000;

	localparam logic [SIZE_WIDTH-1:0] WIDTH_RESET = 13'd640;
	localparam logic [SIZE_WIDTH-1:0] HEIGHT_RESET = 13'd480;
	localparam logic signed [FIX_WIDTH-1:0] SPAN_REAL_RESET = 32'sd939524096;
	localparam logic signed [FIX_WIDTH-1:0] SPAN_IMAG_RESET = 32'sd671088640;
	localparam logic signed [FIX_WIDTH-1:0] CORNER_REAL_RESET = -32'sd671088640;
	localparam logic signed [FIX_WIDTH-1:0] CORNER_IMAG_RESET = -32'sd335544320;
	localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET = 16'd256;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_IMAGE_WIDTH    = 3'd0,
		REG_IMAGE_HEIGHT   = 3'd1,
		REG_SPAN_REAL      = 3'd2,
		REG_SPAN_IMAG      = 3'd3,
		REG_CORNER_REAL    = 3'd4,
		REG_CORNER_IMAG    = 3'd5,
		REG_MAX_ITERATIONS = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_WIDTH-1:0] pixel_x;
		logic [COORD_WIDTH-1:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] escape_count;
		logic                   in_set;
	} result_t;

	// Operand pairs of the shared multiplier.
	typedef enum logic [1:0] {
		MUL_RR,
		MUL_II,
		MUL_RI,
		MUL_NN
	} mul_op_t;

	typedef struct packed {
		logic    load_pix;
		logic    map_start;
		logic    div_step;
		logic    map_store;
		logic    axis;
		logic    mul_en;
		mul_op_t mul_op;
		logic    take_rr;
		logic    take_ii;
		logic    test;
		logic    update;
		logic    finish;
	} cmd_t;

	typedef struct packed {
		logic escape;
		logic overflow;
		logic last;
		logic limit_zero;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

/* hdl/mbe_ctrl.sv */
// Controller state machine that sequences mapping, division and iteration.
`default_nettype none

module mbe_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output mbe_pkg::cmd_t   cmd,
	input  mbe_pkg::status_t status
);
	import mbe_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_MAP_MUL  = 10'b00_0000_0010,
		ST_MAP_DIV  = 10'b00_0000_0100,
		ST_MAP_FIN  = 10'b00_0000_1000,
		ST_IT_START = 10'b00_0001_0000,
		ST_IT_MII   = 10'b00_0010_0000,
		ST_IT_MRI   = 10'b00_0100_0000,
		ST_IT_TEST  = 10'b00_1000_0000,
		ST_IT_UPD   = 10'b01_0000_0000,
		ST_DONE     = 10'b10_0000_0000
	} state_t;

	localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(DIV_WIDTH - 1);

	state_t state_q, state_d;
	logic axis_q, axis_d;
	logic [DIV_CNT_WIDTH-1:0] div_cnt_q, div_cnt_d;
	logic accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		axis_d = axis_q;
		div_cnt_d = div_cnt_q;
		cmd = '0;
		cmd.mul_op = MUL_RR;
		cmd.axis = axis_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_pix = accept;
				if (accept) begin
					axis_d = 1'b0;
					state_d = ST_MAP_MUL;
				end
			end
			ST_MAP_MUL: begin
				cmd.map_start = 1'b1;
				div_cnt_d = '0;
				state_d = ST_MAP_DIV;
			end
			ST_MAP_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_MAP_FIN;
				end else begin
					div_cnt_d = div_cnt_q + 1'b1;
				end
			end
			ST_MAP_FIN: begin
				cmd.map_store = 1'b1;
				if (!axis_q) begin
					axis_d = 1'b1;
					state_d = ST_MAP_MUL;
				end else if (status.limit_zero) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_IT_START;
				end
			end
			ST_IT_START: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_RR;
				state_d = ST_IT_MII;
			end
			ST_IT_MII: begin
				cmd.take_rr = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_II;
				state_d = ST_IT_MRI;
			end
			ST_IT_MRI: begin
				cmd.take_ii = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_RI;
				state_d = ST_IT_TEST;
			end
			ST_IT_TEST: begin
				cmd.test = 1'b1;
				state_d = status.escape ? ST_DONE : ST_IT_UPD;
			end
			ST_IT_UPD: begin
				// The square of the new real part starts here; it is dropped on exit.
				cmd.update = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_NN;
				state_d = (status.overflow || status.last) ? ST_DONE : ST_IT_MII;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			axis_q <= axis_d;
			div_cnt_q <= div_cnt_d;
		end
	end

endmodule

`default_nettype wire

/* hdl/mbe_datapath.sv */
// Datapath: configuration registers, coordinate divider, iteration unit, result register.
`default_nettype none

module mbe_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mbe_pkg::pixel_t                        in_data,
	input  logic                                   cfg_write,
	input  logic [mbe_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [mbe_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
	input  mbe_pkg::cmd_t                          cmd,
	output mbe_pkg::status_t                       status,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output mbe_pkg::result_t                       out_data
);
	import mbe_pkg::*;

	// Configuration registers.
	logic [SIZE_WIDTH-1:0] width_q, height_q;
	logic signed [FIX_WIDTH-1:0] span_re_q, span_im_q, corner_re_q, corner_im_q;
	logic [ITER_WIDTH-1:0] max_q;

	// Mapping and division.
	logic [COORD_WIDTH-1:0] px_q, py_q;
	logic map_neg_q;
	logic [DIV_WIDTH-1:0] num_q;
	logic [SIZE_WIDTH-1:0] den_q, rem_q;

	// Iteration.
	logic signed [FIX_WIDTH-1:0] cr_q, ci_q, zr_q, zi_q;
	logic signed [PROD_WIDTH-1:0] prod_q, rr_q, ii_q, nr_q, ni_q;
	logic [ITER_WIDTH-1:0] cnt_q;

	logic out_valid_q;
	result_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			span_re_q <= SPAN_REAL_RESET;
			span_im_q <= SPAN_IMAG_RESET;
			corner_re_q <= CORNER_REAL_RESET;
			corner_im_q <= CORNER_IMAG_RESET;
			max_q <= MAX_ITER_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:    width_q <= cfg_data[SIZE_WIDTH-1:0];
				REG_IMAGE_HEIGHT:   height_q <= cfg_data[SIZE_WIDTH-1:0];
				REG_SPAN_REAL:      span_re_q <= signed'(cfg_data[FIX_WIDTH-1:0]);
				REG_SPAN_IMAG:      span_im_q <= signed'(cfg_data[FIX_WIDTH-1:0]);
				REG_CORNER_REAL:    corner_re_q <= signed'(cfg_data[FIX_WIDTH-1:0]);
				REG_CORNER_IMAG:    corner_im_q <= signed'(cfg_data[FIX_WIDTH-1:0]);
				REG_MAX_ITERATIONS: max_q <= cfg_data[ITER_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Axis selection and the magnitude of span times pixel.
	logic signed [FIX_WIDTH-1:0] span_sel, corner_sel;
	logic [FIX_WIDTH-1:0] span_abs;
	logic [COORD_WIDTH-1:0] pix_sel;
	logic [SIZE_WIDTH-1:0] size_sel;
	logic [FIX_WIDTH+COORD_WIDTH-1:0] map_prod;

	assign span_sel = cmd.axis ? span_im_q : span_re_q;
	assign corner_sel = cmd.axis ? corner_im_q : corner_re_q;
	assign pix_sel = cmd.axis ? py_q : px_q;
	assign size_sel = cmd.axis ? height_q : width_q;
	assign span_abs = span_sel[FIX_WIDTH-1] ? (~span_sel + 1'b1) : span_sel;
	assign map_prod = span_abs * pix_sel;

	// One restoring division step: shift in a dividend bit, subtract if it fits.
	logic [SIZE_WIDTH:0] partial;
	logic [SIZE_WIDTH:0] part_diff;
	logic q_bit;

	assign partial = {rem_q, num_q[DIV_WIDTH-1]};
	assign part_diff = partial - {1'b0, den_q};
	assign q_bit = (partial >= {1'b0, den_q});

	// Signed quotient added to the corner, saturated to the fixed-point range.
	logic [DIV_WIDTH:0] q_mag;
	logic signed [DIV_WIDTH:0] q_signed;
	logic signed [DIV_WIDTH+1:0] map_sum;
	logic [DIV_WIDTH+1-FIX_WIDTH+1:0] sum_hi;
	logic signed [FIX_WIDTH-1:0] map_sat;

	assign q_mag = {1'b0, num_q};
	assign q_signed = map_neg_q ? -signed'(q_mag) : signed'(q_mag);
	assign map_sum = (DIV_WIDTH+2)'(corner_sel) + (DIV_WIDTH+2)'(q_signed);
	assign sum_hi = map_sum[DIV_WIDTH+1:FIX_WIDTH-1];
	assign map_sat = (&sum_hi || ~|sum_hi) ? map_sum[FIX_WIDTH-1:0]
		: (map_sum[DIV_WIDTH+1] ? FIX_MIN : FIX_MAX);

	always_ff @(posedge clk) begin
		if (cmd.load_pix) begin
			px_q <= in_data.pixel_x;
			py_q <= in_data.pixel_y;
		end
		if (cmd.map_start) begin
			map_neg_q <= span_sel[FIX_WIDTH-1];
			num_q <= map_prod[DIV_WIDTH-1:0];
			rem_q <= '0;
			den_q <= (size_sel == '0) ? SIZE_WIDTH'(1) : size_sel;
		end else if (cmd.div_step) begin
			num_q <= {num_q[DIV_WIDTH-2:0], q_bit};
			rem_q <= q_bit ? part_diff[SIZE_WIDTH-1:0] : partial[SIZE_WIDTH-1:0];
		end
		if (cmd.map_store) begin
			if (cmd.axis) begin
				ci_q <= map_sat;
			end else begin
				cr_q <= map_sat;
			end
		end
	end

	// Shared multiplier, one product per cycle.
	logic signed [FIX_WIDTH-1:0] mul_a, mul_b;
	logic signed [PROD_WIDTH-1:0] mul_p;

	always_comb begin
		unique case (cmd.mul_op)
			MUL_RR: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			MUL_II: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			MUL_RI: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			MUL_NN: begin
				mul_a = nr_q[FIX_WIDTH-1:0];
				mul_b = nr_q[FIX_WIDTH-1:0];
			end
			default: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Both squares are non-negative and at most 2^62, so the sum cannot wrap.
	logic [PROD_WIDTH-1:0] mag;
	logic signed [PROD_WIDTH-1:0] nr_d, ni_d;
	logic [PROD_WIDTH-FIX_WIDTH:0] nr_hi, ni_hi;
	logic [ITER_WIDTH:0] cnt_next;

	assign mag = rr_q + ii_q;
	assign nr_d = (rr_q >>> FRAC_BITS) - (ii_q >>> FRAC_BITS) + PROD_WIDTH'(cr_q);
	assign ni_d = ((prod_q >>> FRAC_BITS) <<< 1) + PROD_WIDTH'(ci_q);
	assign nr_hi = nr_q[PROD_WIDTH-1:FIX_WIDTH-1];
	assign ni_hi = ni_q[PROD_WIDTH-1:FIX_WIDTH-1];
	assign cnt_next = (ITER_WIDTH+1)'(cnt_q) + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.take_rr) begin
			rr_q <= prod_q;
		end
		if (cmd.take_ii) begin
			ii_q <= prod_q;
		end
		if (cmd.test) begin
			nr_q <= nr_d;
			ni_q <= ni_d;
		end
		if (cmd.load_pix) begin
			zr_q <= '0;
			zi_q <= '0;
			cnt_q <= '0;
		end else if (cmd.update) begin
			zr_q <= nr_q[FIX_WIDTH-1:0];
			zi_q <= ni_q[FIX_WIDTH-1:0];
			cnt_q <= cnt_next[ITER_WIDTH-1:0];
		end
		if (cmd.finish) begin
			out_q.in_set <= !(cnt_q < max_q);
			out_q.escape_count <= (cnt_q < max_q) ? COUNT_WIDTH'(cnt_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.escape = ((mag >> FRAC_BITS) >= ESC_LIMIT);
	assign status.overflow = !((&nr_hi || ~|nr_hi) && (&ni_hi || ~|ni_hi));
	assign status.last = (cnt_next >= (ITER_WIDTH+1)'(max_q));
	assign status.limit_zero = (max_q == '0);
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

`default_nettype wire

/* hdl/mandelbrot_escape_time.sv */
// Top level of the Mandelbrot escape-time evaluator.
//
// One pixel (pixel_x, pixel_y) is taken per input transfer on in_valid/in_stall.
// The pixel is mapped to c = corner + span * pixel / size for each axis, then
// z = z*z + c is iterated from zero until |z|^2 >= 4, z overflows, or the
// iteration limit is reached. One result (escape_count, in_set) follows on
// out_valid/out_stall for every pixel, in order.
// Each axis is mapped through the one-bit-per-cycle divider, and each iteration
// forms its three products in turn on one 32x32 multiplier. Items are worked
// one at a time; the next pixel is accepted in the cycle after the result is
// written. A finished result waits in the output register; the next pixel is
// accepted while it waits, but no further result is written until it is taken,
// so a stalling receiver holds the block at the end of its current pixel.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once and
// belong to idle periods. Reset restores the default view and iteration limit,
// empties the output register and leaves the block ready for a pixel.
`default_nettype none

module mandelbrot_escape_time (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  mbe_pkg::pixel_t                     in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output mbe_pkg::result_t                    out_data,
	input  logic                                cfg_write,
	input  logic [mbe_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [mbe_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
	import mbe_pkg::*;

	cmd_t cmd;
	status_t status;

	mbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status)
	);

	mbe_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* hdl/mbe_checker.sv */
// Port-level assertion checker for the escape-time block and its bind.
`default_nettype none
`include "mandelbrot_escape_time_macros.svh"

module mbe_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input mbe_pkg::result_t out_data
);
	import mbe_pkg::*;

	// A stalled result stays offered and unchanged.
	`MBE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

	// A point inside the set never carries a count.
	`MBE_ASSERT(a_in_set_zero, out_valid && out_data.in_set |-> out_data.escape_count == '0, "in-set result with nonzero count")

	// After a pixel transfer the block is busy on it in the next cycle.
	`MBE_ASSERT(a_busy_after_transfer, in_valid && !in_stall |=> in_stall, "input taken again right after a transfer")

	// A new result appears only at the end of work on a pixel.
	`MBE_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(in_stall), "result appeared while idle")

	`MBE_ASSERT_IN_RESET(a_reset_empty, !arst_n |-> !out_valid, "result offered during reset")

endmodule

bind mandelbrot_escape_time mbe_checker u_checker (.*);

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the Mandelbrot escape-time block with a predicting scoreboard.
`default_nettype none

class escape_scoreboard;

	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -WORD_MAX - 1;
	localparam int FRAC = 28;
	// |z|^2 >= 4 compared on the exact sum of squares, which carries 2*FRAC fraction bits.
	localparam logic [63:0] ESCAPE_MAG = 64'd4 << (2 * FRAC);

	logic [12:0]        width_q;
	logic [12:0]        height_q;
	logic signed [31:0] span_re;
	logic signed [31:0] span_im;
	logic signed [31:0] corner_re;
	logic signed [31:0] corner_im;
	logic [15:0]        iter_limit;

	mbe_pkg::result_t expected_results[$];
	int errors;
	int checked;

	function new();
		width_q = 13'd640;
		height_q = 13'd480;
		span_re = 32'sd939524096;
		span_im = 32'sd671088640;
		corner_re = -32'sd671088640;
		corner_im = -32'sd335544320;
		iter_limit = 16'd256;
		errors = 0;
		checked = 0;
	endfunction

	function void set_reg(mbe_pkg::cfg_reg_t idx, logic [31:0] data);
		case (idx)
			mbe_pkg::REG_IMAGE_WIDTH:    width_q = data[12:0];
			mbe_pkg::REG_IMAGE_HEIGHT:   height_q = data[12:0];
			mbe_pkg::REG_SPAN_REAL:      span_re = data;
			mbe_pkg::REG_SPAN_IMAG:      span_im = data;
			mbe_pkg::REG_CORNER_REAL:    corner_re = data;
			mbe_pkg::REG_CORNER_IMAG:    corner_im = data;
			mbe_pkg::REG_MAX_ITERATIONS: iter_limit = data[15:0];
			default: ;
		endcase
	endfunction

	// corner + span * pixel / size, quotient truncated toward zero, sum saturated.
	function longint map_axis(logic signed [31:0] span, logic signed [31:0] corner,
			logic [11:0] pix, logic [12:0] size);
		longint divisor;
		longint sum;
		divisor = (size == 13'd0) ? 64'sd1 : longint'(size);
		sum = longint'(corner) + (longint'(span) * longint'(pix)) / divisor;
		if (sum > WORD_MAX)
			return WORD_MAX;
		if (sum < WORD_MIN)
			return WORD_MIN;
		return sum;
	endfunction

	function mbe_pkg::result_t escape_time(mbe_pkg::pixel_t p);
		longint cr, ci, zr, zi, sq_re, sq_im, nr, ni;
		logic [63:0] mag;
		int unsigned n;
		mbe_pkg::result_t r;
		cr = map_axis(span_re, corner_re, p.pixel_x, width_q);
		ci = map_axis(span_im, corner_im, p.pixel_y, height_q);
		zr = 0;
		zi = 0;
		n = 0;
		while (n < iter_limit) begin
			sq_re = zr * zr;
			sq_im = zi * zi;
			mag = 64'(sq_re) + 64'(sq_im);
			if (mag >= ESCAPE_MAG)
				break;
			nr = (sq_re >>> FRAC) - (sq_im >>> FRAC) + cr;
			ni = 2 * ((zr * zi) >>> FRAC) + ci;
			n++;
			// An overflowing z still counts the iteration and ends the loop, as an escape unless the limit was reached.
			if (nr > WORD_MAX || nr < WORD_MIN || ni > WORD_MAX || ni < WORD_MIN)
				break;
			zr = nr;
			zi = ni;
		end
		r = '0;
		if (n < iter_limit)
			r.escape_count = 16'(n);
		else
			r.in_set = 1'b1;
		return r;
	endfunction

	function void note_pixel(mbe_pkg::pixel_t p);
		expected_results.push_back(escape_time(p));
	endfunction

	task report(string msg);
		$display("mismatch at result %0d: %s", checked, msg);
		errors++;
	endtask

	task check_result(mbe_pkg::result_t got);
		mbe_pkg::result_t want;
		if (expected_results.size() == 0) begin
			report("result transfer with no pixel outstanding");
		end else begin
			want = expected_results.pop_front();
			if (got.escape_count !== want.escape_count)
				report($sformatf("escape_count %0d, expected %0d",
					got.escape_count, want.escape_count));
			if (got.in_set !== want.in_set)
				report($sformatf("in_set %b, expected %b", got.in_set, want.in_set));
		end
		checked++;
	endtask

endclass

module tb;

	import mbe_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	localparam int QUIET_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 400;
	localparam int Q_UNIT = 262144;

	typedef enum logic [1:0] {
		STALL_NEVER,
		STALL_HALF,
		STALL_MOST
	} stall_mode_t;

	typedef struct packed {
		logic [31:0] width;
		logic [31:0] height;
		logic [31:0] span_re;
		logic [31:0] span_im;
		logic [31:0] corner_re;
		logic [31:0] corner_im;
		logic [31:0] limit;
	} view_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_stall;
	pixel_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	result_t out_data;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

	escape_scoreboard sb = new();

	stall_mode_t stall_mode = STALL_NEVER;
	int stall_left = 0;
	int quiet_cycles = 0;

	mandelbrot_escape_time dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_pixel(in_data);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// The receiver picks a new stall mode at random whenever its countdown runs out.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 2));
			stall_left <= $urandom_range(10, 400);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NEVER: out_stall <= 1'b0;
			STALL_HALF:  out_stall <= $urandom_range(0, 1);
			default:     out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	function automatic pixel_t px(int x, int y);
		pixel_t p;
		p.pixel_x = 12'(x);
		p.pixel_y = 12'(y);
		return p;
	endfunction

	function automatic view_t random_view();
		view_t v;
		int sel;
		int pick;
		sel = $urandom_range(0, 9);
		if (sel < 7) begin
			// A view near the set, so that escape counts spread out.
			v.width = $urandom_range(1, 4096);
			v.height = $urandom_range(1, 4096);
			v.corner_re = (int'($urandom_range(0, 2662)) - 2253) * Q_UNIT;
			v.corner_im = (int'($urandom_range(0, 2458)) - 1229) * Q_UNIT;
			v.span_re = int'($urandom_range(1, 3072)) * Q_UNIT;
			v.span_im = int'($urandom_range(1, 3072)) * Q_UNIT;
			if ($urandom_range(0, 3) == 0)
				v.span_re = -v.span_re;
			if ($urandom_range(0, 3) == 0)
				v.span_im = -v.span_im;
		end else begin
			v.width = (sel == 9) ? $urandom_range(0, 16) : $urandom_range(0, 8191);
			v.height = (sel == 9) ? $urandom_range(0, 16) : $urandom_range(0, 8191);
			v.span_re = $urandom();
			v.span_im = $urandom();
			v.corner_re = $urandom();
			v.corner_im = $urandom();
		end
		pick = $urandom_range(0, 15);
		if (pick == 0)
			v.limit = 0;
		else if (pick < 3)
			v.limit = $urandom_range(100, 300);
		else
			v.limit = $urandom_range(1, 48);
		// Bits above the register widths must be ignored.
		if ($urandom_range(0, 3) == 0) begin
			v.width[31:13] = 19'($urandom());
			v.height[31:13] = 19'($urandom());
			v.limit[31:16] = 16'($urandom());
		end
		return v;
	endfunction

	function automatic pixel_t random_pixel(view_t v);
		pixel_t p;
		int w;
		int h;
		w = int'(v.width[12:0]);
		h = int'(v.height[12:0]);
		w = (w == 0) ? 1 : ((w > 4096) ? 4096 : w);
		h = (h == 0) ? 1 : ((h > 4096) ? 4096 : h);
		if ($urandom_range(0, 3) == 0)
			p = pixel_t'($urandom());
		else
			p = px($urandom_range(0, w - 1), $urandom_range(0, h - 1));
		return p;
	endfunction

	task automatic send_pixel(input pixel_t p);
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic idle_input(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles)
			@(posedge clk);
	endtask

	// Holds the input off until every transfer in flight has produced its result.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.expected_results.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic apply_view(input view_t v);
		write_reg(REG_IMAGE_WIDTH, v.width);
		write_reg(REG_IMAGE_HEIGHT, v.height);
		write_reg(REG_SPAN_REAL, v.span_re);
		write_reg(REG_SPAN_IMAG, v.span_im);
		write_reg(REG_CORNER_REAL, v.corner_re);
		write_reg(REG_CORNER_IMAG, v.corner_im);
		write_reg(REG_MAX_ITERATIONS, v.limit);
		cfg_write <= 1'b0;
	endtask

	initial begin
		view_t v;
		int sent;
		int count;
		int burst;
		int k;

		// The falling edge of reset at the start clears the block before the first clock.
		arst_n <= 1'b0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset view: corners, a point inside the set, coordinates that saturate c.
		send_pixel(px(0, 0));
		send_pixel(px(4095, 4095));
		send_pixel(px(4095, 0));
		send_pixel(px(0, 4095));
		send_pixel(px(457, 240));
		send_pixel(px(160, 240));
		drain();

		// Zero image sizes act as one; c saturates toward both ends of the range.
		apply_view(view_t'{width: 32'd0, height: 32'd0, span_re: 32'h7FFF_FFFF,
			span_im: 32'h8000_0000, corner_re: 32'h7FFF_FFFF, corner_im: 32'h8000_0000,
			limit: 32'd65535});
		send_pixel(px(0, 0));
		send_pixel(px(4095, 4095));
		send_pixel(px(1, 0));
		drain();

		// c is zero, so the point stays inside through the largest limit.
		apply_view(view_t'{width: 32'd8191, height: 32'hFFFF_E001, span_re: 32'd0,
			span_im: 32'd0, corner_re: 32'd0, corner_im: 32'd0, limit: 32'hFFFF_FFFF});
		send_pixel(px(4095, 4095));
		drain();

		// A zero limit reports every pixel as inside the set.
		apply_view(view_t'{width: 32'd640, height: 32'd480, span_re: 32'd939524096,
			span_im: 32'd671088640, corner_re: -32'sd671088640,
			corner_im: -32'sd335544320, limit: 32'd0});
		send_pixel(px(0, 0));
		send_pixel(px(457, 240));
		send_pixel(px(4095, 4095));
		drain();

		// Negative span with sizes that leave a remainder, so the quotient truncates.
		apply_view(view_t'{width: 32'd3, height: 32'd7, span_re: -32'sd939524093,
			span_im: 32'd671088641, corner_re: 32'd268435456,
			corner_im: -32'sd335544320, limit: 32'h1234_0002});
		send_pixel(px(1, 1));
		send_pixel(px(2, 5));
		send_pixel(px(0, 0));
		drain();

		sent = 0;
		burst = $urandom_range(1, 6);
		while (sent < RANDOM_ITEMS) begin
			v = random_view();
			apply_view(v);
			count = $urandom_range(20, 80);
			for (k = 0; k < count; k++) begin
				send_pixel(random_pixel(v));
				sent++;
				if ($urandom_range(0, 49) == 0) begin
					drain();
				end else begin
					burst = burst - 1;
					if (burst == 0) begin
						idle_input(($urandom_range(0, 3) == 0) ?
							$urandom_range(20, 300) : $urandom_range(1, 4));
						burst = ($urandom_range(0, 4) == 0) ?
							$urandom_range(20, 60) : $urandom_range(1, 6);
					end
				end
			end
			drain();
		end

		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
